// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

// ----- rtl/i2cm_pkg.sv -----
// shared types and constants for the i2c master byte engine
// no dependencies
package i2cm_pkg;

	localparam int HALF_W = 16;
	localparam int TIMER_WIDTH_DEF = 16;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd8;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// command codes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// bus phases, one-hot
	typedef enum logic [16:0] {
		PH_IDLE       = 17'b00000000000000001,
		PH_ST_REL_SDA = 17'b00000000000000010,
		PH_ST_REL_SCL = 17'b00000000000000100,
		PH_ST_SDA_LOW = 17'b00000000000001000,
		PH_SP_LOW     = 17'b00000000000010000,
		PH_SP_REL_SCL = 17'b00000000000100000,
		PH_SP_REL_SDA = 17'b00000000001000000,
		PH_WR_LOW     = 17'b00000000010000000,
		PH_WR_HIGH    = 17'b00000000100000000,
		PH_WA_LOW     = 17'b00000001000000000,
		PH_WA_HIGH    = 17'b00000010000000000,
		PH_RD_REL     = 17'b00000100000000000,
		PH_RD_STRETCH = 17'b00001000000000000,
		PH_RD_LOW     = 17'b00010000000000000,
		PH_RD_HIGH    = 17'b00100000000000000,
		PH_RK_LOW     = 17'b01000000000000000,
		PH_RK_HIGH    = 17'b10000000000000000
	} phase_t;

	// one tick of input
	typedef struct packed {
		logic       cmd_valid;
		op_t        operation;
		logic [7:0] write_byte;
		logic       nack_after_read;
		logic       sda_in;
		logic       scl_in;
	} tick_t;

	// one tick of result
	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       ready_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_level;
	} res_t;

endpackage

// ----- rtl/i2cm_fsm.sv -----
// phase sequencer of the i2c master: bus state, timer and byte shifter
// depends on i2cm_pkg
module i2cm_fsm import i2cm_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tick_t             tick,
	input  logic [HALF_W-1:0] half_period,
	output res_t              res
);

	localparam int LOAD_W = (TIMER_WIDTH < HALF_W) ? TIMER_WIDTH : HALF_W;

	phase_t                 phase_q, phase_d;
	logic [3:0]             bits_q, bits_d;
	logic [7:0]             shift_q, shift_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic                   nack_q, nack_d;
	logic [7:0]             last_read_q, last_read_d;
	logic                   last_ack_q, last_ack_d;
	logic                   scl_low_q, scl_low_d;
	logic                   sda_low_q, sda_low_d;
	logic                   done;
	logic [TIMER_WIDTH-1:0] load_v;
	logic [7:0]             shift_next;
	logic [3:0]             bits_next;

	// phase length, zero counts as one tick
	always_comb begin
		load_v = '0;
		load_v[LOAD_W-1:0] = half_period[LOAD_W-1:0];
		if (load_v == '0) begin
			load_v = TIMER_WIDTH'(1);
		end
	end

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		bits_d      = bits_q;
		shift_d     = shift_q;
		timer_d     = timer_q;
		nack_d      = nack_q;
		last_read_d = last_read_q;
		last_ack_d  = last_ack_q;
		scl_low_d   = scl_low_q;
		sda_low_d   = sda_low_q;
		done        = 1'b0;
		bits_next   = bits_q + 4'd1;
		shift_next  = {shift_q[6:0], 1'b0};

		if (phase_q == PH_IDLE) begin
			if (tick.cmd_valid) begin
				bits_d  = '0;
				timer_d = load_v;
				unique case (tick.operation)
					OP_START: begin
						phase_d   = PH_ST_REL_SDA;
						sda_low_d = 1'b0;
					end
					OP_STOP: begin
						phase_d   = PH_SP_LOW;
						scl_low_d = 1'b1;
						sda_low_d = 1'b1;
					end
					OP_WRITE: begin
						phase_d   = PH_WR_LOW;
						shift_d   = tick.write_byte;
						scl_low_d = 1'b1;
						sda_low_d = ~tick.write_byte[7];
					end
					OP_READ: begin
						phase_d   = PH_RD_REL;
						shift_d   = '0;
						nack_d    = tick.nack_after_read;
						scl_low_d = 1'b0;
						sda_low_d = 1'b0;
					end
					default: ;
				endcase
			end
		end else if (phase_q == PH_RD_STRETCH) begin
			// slave may hold scl low, no timeout
			if (tick.scl_in) begin
				phase_d   = PH_RD_LOW;
				scl_low_d = 1'b1;
				sda_low_d = 1'b0;
				timer_d   = load_v;
			end
		end else if (timer_q > TIMER_WIDTH'(1)) begin
			timer_d = timer_q - TIMER_WIDTH'(1);
		end else begin
			timer_d = load_v;
			unique case (phase_q)
				PH_ST_REL_SDA: begin
					phase_d   = PH_ST_REL_SCL;
					scl_low_d = 1'b0;
					sda_low_d = 1'b0;
				end
				PH_ST_REL_SCL: begin
					phase_d   = PH_ST_SDA_LOW;
					scl_low_d = 1'b0;
					sda_low_d = 1'b1;
				end
				PH_ST_SDA_LOW: begin
					scl_low_d = 1'b1;
					done      = 1'b1;
				end
				PH_SP_LOW: begin
					phase_d   = PH_SP_REL_SCL;
					scl_low_d = 1'b0;
					sda_low_d = 1'b1;
				end
				PH_SP_REL_SCL: begin
					phase_d   = PH_SP_REL_SDA;
					scl_low_d = 1'b0;
					sda_low_d = 1'b0;
				end
				PH_SP_REL_SDA: begin
					done = 1'b1;
				end
				PH_WR_LOW: begin
					phase_d   = PH_WR_HIGH;
					scl_low_d = 1'b0;
				end
				PH_WR_HIGH: begin
					shift_d   = shift_next;
					bits_d    = bits_next;
					scl_low_d = 1'b1;
					if (bits_next >= BITS_PER_BYTE) begin
						phase_d   = PH_WA_LOW;
						sda_low_d = 1'b0;
					end else begin
						phase_d   = PH_WR_LOW;
						sda_low_d = ~shift_next[7];
					end
				end
				PH_WA_LOW: begin
					phase_d   = PH_WA_HIGH;
					scl_low_d = 1'b0;
					sda_low_d = 1'b0;
				end
				PH_WA_HIGH: begin
					last_ack_d = tick.sda_in;
					scl_low_d  = 1'b1;
					done       = 1'b1;
				end
				PH_RD_REL: begin
					phase_d = PH_RD_STRETCH;
					timer_d = '0;
				end
				PH_RD_LOW: begin
					phase_d   = PH_RD_HIGH;
					scl_low_d = 1'b0;
					sda_low_d = 1'b0;
				end
				PH_RD_HIGH: begin
					// sample on the last tick of scl high
					shift_d   = {shift_q[6:0], tick.sda_in};
					bits_d    = bits_next;
					scl_low_d = 1'b1;
					if (bits_next >= BITS_PER_BYTE) begin
						phase_d   = PH_RK_LOW;
						sda_low_d = ~nack_q;
					end else begin
						phase_d   = PH_RD_LOW;
						sda_low_d = 1'b0;
					end
				end
				PH_RK_LOW: begin
					phase_d   = PH_RK_HIGH;
					scl_low_d = 1'b0;
				end
				PH_RK_HIGH: begin
					scl_low_d   = 1'b1;
					last_read_d = shift_q;
					done        = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (done) begin
				phase_d = PH_IDLE;
				timer_d = '0;
			end
		end
	end

	// state registers, updated once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_q      <= '0;
			shift_q     <= '0;
			timer_q     <= '0;
			nack_q      <= 1'b0;
			last_read_q <= '0;
			last_ack_q  <= 1'b1;
			scl_low_q   <= 1'b0;
			sda_low_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			bits_q      <= bits_d;
			shift_q     <= shift_d;
			timer_q     <= timer_d;
			nack_q      <= nack_d;
			last_read_q <= last_read_d;
			last_ack_q  <= last_ack_d;
			scl_low_q   <= scl_low_d;
			sda_low_q   <= sda_low_d;
		end
	end

	// result shows the state after this tick
	always_comb begin
		res.scl_drive_low = scl_low_d;
		res.sda_drive_low = sda_low_d;
		res.ready_res     = (phase_d == PH_IDLE);
		res.done_res      = done;
		res.read_byte     = last_read_d;
		res.ack_level     = last_ack_d;
	end

endmodule

// ----- rtl/i2c_master_byte_engine.sv -----
// top level of the i2c master byte engine: handshake, config, input and result registers
// depends on i2cm_pkg and i2cm_fsm
//
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | in_valid/in_ready  | cmd_valid operation write_byte
//          |                    | nack_after_read sda_in scl_in
// result   | out_valid/out_ready| scl_drive_low sda_drive_low ready_res
//          |                    | done_res read_byte ack_level
// config   | cfg_write_en       | cfg_write_data (half period, ticks)
//
// one item per cycle while the result is not stalled: an item is held in the input
// register, the phase sequencer updates from it, and the result is registered in the
// output register.
// reset clears the sequencer state, not the result register; half period resets to 8.
// a stalled result holds the input register, which then holds the input channel.
module i2c_master_byte_engine import i2cm_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd_valid,
	input  logic [1:0]        operation,
	input  logic [7:0]        write_byte,
	input  logic              nack_after_read,
	input  logic              sda_in,
	input  logic              scl_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              scl_drive_low,
	output logic              sda_drive_low,
	output logic              ready_res,
	output logic              done_res,
	output logic [7:0]        read_byte,
	output logic              ack_level,
	input  logic              cfg_write_en,
	input  logic [HALF_W-1:0] cfg_write_data
);

	logic [HALF_W-1:0] half_q;
	logic              valid_s1;
	tick_t             tick_s1;
	logic              valid_s2;
	res_t              res_s2;
	res_t              res;
	logic              out_free;
	logic              step;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_write_en) begin
			half_q <= cfg_write_data;
		end
	end

	// flow control
	assign out_free = !valid_s2 || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1.cmd_valid       <= cmd_valid;
			tick_s1.operation       <= op_t'(operation);
			tick_s1.write_byte      <= write_byte;
			tick_s1.nack_after_read <= nack_after_read;
			tick_s1.sda_in          <= sda_in;
			tick_s1.scl_in          <= scl_in;
		end
	end

	i2cm_fsm #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.tick        (tick_s1),
		.half_period (half_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign scl_drive_low = res_s2.scl_drive_low;
	assign sda_drive_low = res_s2.sda_drive_low;
	assign ready_res     = res_s2.ready_res;
	assign done_res      = res_s2.done_res;
	assign read_byte     = res_s2.read_byte;
	assign ack_level     = res_s2.ack_level;

endmodule

// ----- rtl/i2cm_checker.sv -----
// port-level checks for the i2c master byte engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module i2cm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic scl_drive_low,
	input logic sda_drive_low,
	input logic ready_res,
	input logic done_res
);

	// a finished command always leaves the engine idle
	`ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid && done_res, ready_res)

	// a command ends with scl held low or with the bus free
	`ASSERT_IMPL(a_done_bus, clk, arst_n, out_valid && done_res, scl_drive_low || !sda_drive_low)

	// input only backs up behind a stalled result
	`ASSERT_IMPL(a_backpressure, clk, arst_n, !in_ready, out_valid && !out_ready)

	// a stalled result keeps its line levels
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(scl_drive_low) && $stable(sda_drive_low))

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);
